@@ hw/rtl/plp_pkg.sv @@
// shared widths, limits and helpers for the point to line projection pipeline
// no dependencies; imported by every module of the block
package plp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int DIFF_W        = COORD_W + 1;
	localparam int PROD_W        = 2 * DIFF_W;
	localparam int SUM_W         = PROD_W + 2;
	localparam int LAM_W         = 32;
	localparam int DIST_W        = 33;

	localparam logic [LAM_W-1:0]  LAM_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [LAM_W-1:0]  LAM_NEG_MAG = 32'h8000_0000;
	localparam logic [DIST_W-1:0] DIST_MAX    = 33'h1_FFFF_FFFF;

	// magnitude of a signed coordinate difference
	function automatic logic [DIFF_W-1:0] mag_diff(input logic [DIFF_W-1:0] x);
		return x[DIFF_W-1] ? (~x + 1'b1) : x;
	endfunction

endpackage

@@ hw/rtl/plp_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on plp_pkg
module plp_div
	import plp_pkg::*;
#(
	parameter int NUM_W = SUM_W + FRAC_BITS_DEF + 1,
	parameter int DEN_W = SUM_W,
	parameter int QUO_W = LAM_W,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [SB_W-1:0]  sb,
	output logic             out_valid,
	output logic [QUO_W-1:0] quo,
	output logic [SB_W-1:0]  out_sb
);

	logic [QUO_W-1:0] vld_s;
	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] low_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [SB_W-1:0]  sb_s  [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic             cv;
		logic [DEN_W-1:0] crem;
		logic [DEN_W-1:0] cden;
		logic [QUO_W-1:0] clow;
		logic [QUO_W-1:0] cq;
		logic [SB_W-1:0]  csb;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             take;

		if (i == 0) begin : g_head
			// upper dividend bits, below the divisor unless the quotient overflows
			assign cv   = in_valid;
			assign crem = DEN_W'(num[NUM_W-1:QUO_W]);
			assign clow = num[QUO_W-1:0];
			assign cq   = '0;
			assign cden = den;
			assign csb  = sb;
		end else begin : g_body
			assign cv   = vld_s[i-1];
			assign crem = rem_s[i-1];
			assign clow = low_s[i-1];
			assign cq   = quo_s[i-1];
			assign cden = den_s[i-1];
			assign csb  = sb_s[i-1];
		end

		assign trial = {crem, clow[QUO_W-1]};
		assign diff  = trial - {1'b0, cden};
		assign take  = trial >= {1'b0, cden};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_s[i] <= clow << 1;
				quo_s[i] <= {cq[QUO_W-2:0], take};
				den_s[i] <= cden;
				sb_s[i]  <= csb;
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign quo       = quo_s[QUO_W-1];
	assign out_sb    = sb_s[QUO_W-1];

endmodule

@@ hw/rtl/plp_sqrt.sv @@
// pipelined integer square root, floor of the root, one root bit per stage
// depends on plp_pkg
module plp_sqrt
	import plp_pkg::*;
#(
	parameter int RW   = DIST_W,
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] rad,
	input  logic [SB_W-1:0] sb,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SB_W-1:0] out_sb
);

	logic [RW-1:0]   vld_s;
	logic [RW:0]     rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] rad_s  [RW];
	logic [SB_W-1:0] sb_s   [RW];

	for (genvar i = 0; i < RW; i++) begin : g_step
		logic            cv;
		logic [RW:0]     crem;
		logic [RW-1:0]   croot;
		logic [2*RW-1:0] crad;
		logic [SB_W-1:0] csb;
		logic [RW+2:0]   pre;
		logic [RW+2:0]   trial;
		logic [RW+2:0]   diff;
		logic            take;

		if (i == 0) begin : g_head
			assign cv    = in_valid;
			assign crem  = '0;
			assign croot = '0;
			assign crad  = rad;
			assign csb   = sb;
		end else begin : g_body
			assign cv    = vld_s[i-1];
			assign crem  = rem_s[i-1];
			assign croot = root_s[i-1];
			assign crad  = rad_s[i-1];
			assign csb   = sb_s[i-1];
		end

		assign pre   = {crem, crad[2*RW-1:2*RW-2]};
		assign trial = (RW+3)'({croot, 2'b01});
		assign diff  = pre - trial;
		assign take  = pre >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= take ? diff[RW:0] : pre[RW:0];
				root_s[i] <= {croot[RW-2:0], take};
				rad_s[i]  <= crad << 2;
				sb_s[i]   <= csb;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign out_sb    = sb_s[RW-1];

endmodule

@@ hw/rtl/point_line_projection.sv @@
// point_line_projection: orthogonal projection of a 3d point onto a line
// stages from input transfer to result: 6 front stages, 32 divider
// stages, 7 middle stages, 33 square root stages and the output register
// throughput one item per cycle; the whole pipe advances whenever the output
// register is empty or its result is taken, so a stall freezes every stage
// arst_n clears all valid bits; payload registers are not reset
module point_line_projection
	import plp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	input  logic signed [COORD_W-1:0] start_x,
	input  logic signed [COORD_W-1:0] start_y,
	input  logic signed [COORD_W-1:0] start_z,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	input  logic signed [COORD_W-1:0] end_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [LAM_W-1:0]   line_param,
	output logic [DIST_W-1:0]         dist_along,
	output logic [DIST_W-1:0]         dist_to_line,
	output logic                      degenerate,
	output logic                      param_saturated
);

	// scaled numerator width: |u.v| shifted by the fraction plus half the divisor
	localparam int NUM_W = SUM_W + FRAC_BITS + 1;
	// compare width for the quotient overflow test against vv shifted by 32
	localparam int CMP_W = SUM_W + LAM_W + 1;
	// rounded |lambda*v| after dropping the fraction, then signed w and u - w
	localparam int R_W   = PROD_W - FRAC_BITS;
	localparam int W_W   = R_W + 1;
	localparam int E_W   = W_W + 1;
	localparam int DSB_W = 6 * DIFF_W + 3;
	localparam int ASB_W = LAM_W + 3;

	// global advance: nothing moves while a finished result waits
	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: u = p - a, v = b - a
	logic                   vld_s1;
	logic [2:0][DIFF_W-1:0] u_s1, v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1[0] <= {point_x[COORD_W-1], point_x} - {start_x[COORD_W-1], start_x};
			u_s1[1] <= {point_y[COORD_W-1], point_y} - {start_y[COORD_W-1], start_y};
			u_s1[2] <= {point_z[COORD_W-1], point_z} - {start_z[COORD_W-1], start_z};
			v_s1[0] <= {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
			v_s1[1] <= {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
			v_s1[2] <= {end_z[COORD_W-1], end_z} - {start_z[COORD_W-1], start_z};
		end
	end

	// stage 2: magnitude products |u||v| and |v|^2, sign of each u.v term
	logic                   vld_s2, zero_s2;
	logic [2:0][PROD_W-1:0] uv_s2, vsq_s2;
	logic [2:0]             sgn_s2;
	logic [2:0][DIFF_W-1:0] u_s2, v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				uv_s2[k]  <= PROD_W'(mag_diff(u_s1[k])) * PROD_W'(mag_diff(v_s1[k]));
				vsq_s2[k] <= PROD_W'(mag_diff(v_s1[k])) * PROD_W'(mag_diff(v_s1[k]));
				sgn_s2[k] <= u_s1[k][DIFF_W-1] ^ v_s1[k][DIFF_W-1];
			end
			zero_s2 <= (v_s1 == '0);
			u_s2    <= u_s1;
			v_s2    <= v_s1;
		end
	end

	// stage 3: positive and negative parts of u.v, and v.v
	logic                   vld_s3, zero_s3;
	logic [SUM_W-1:0]       pos_s3, neg_s3, vv_s3;
	logic [2:0][DIFF_W-1:0] u_s3, v_s3;
	logic [SUM_W-1:0]       pos_c, neg_c, vv_c;

	always_comb begin
		pos_c = '0;
		neg_c = '0;
		vv_c  = '0;
		for (int k = 0; k < 3; k++) begin
			if (sgn_s2[k]) begin
				neg_c = neg_c + SUM_W'(uv_s2[k]);
			end else begin
				pos_c = pos_c + SUM_W'(uv_s2[k]);
			end
			vv_c = vv_c + SUM_W'(vsq_s2[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s3  <= pos_c;
			neg_s3  <= neg_c;
			vv_s3   <= vv_c;
			zero_s3 <= zero_s2;
			u_s3    <= u_s2;
			v_s3    <= v_s2;
		end
	end

	// stage 4: |u.v| and its sign
	logic                   vld_s4, zero_s4, neg_s4;
	logic [SUM_W-1:0]       num_s4, vv_s4;
	logic [2:0][DIFF_W-1:0] u_s4, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s4  <= pos_s3 < neg_s3;
			num_s4  <= (pos_s3 < neg_s3) ? (neg_s3 - pos_s3) : (pos_s3 - neg_s3);
			vv_s4   <= vv_s3;
			zero_s4 <= zero_s3;
			u_s4    <= u_s3;
			v_s4    <= v_s3;
		end
	end

	// stage 5: scaled numerator with half the divisor for round to nearest
	logic                   vld_s5, zero_s5, neg_s5;
	logic [NUM_W-1:0]       nume_s5;
	logic [SUM_W-1:0]       vv_s5;
	logic [2:0][DIFF_W-1:0] u_s5, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nume_s5 <= (NUM_W'(num_s4) << FRAC_BITS) + NUM_W'(vv_s4 >> 1);
			vv_s5   <= vv_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			u_s5    <= u_s4;
			v_s5    <= v_s4;
		end
	end

	// stage 6: quotient overflow test, lambda needs more than 32 bits
	logic                   vld_s6, zero_s6, neg_s6, big_s6;
	logic [NUM_W-1:0]       nume_s6;
	logic [SUM_W-1:0]       vv_s6;
	logic [2:0][DIFF_W-1:0] u_s6, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s6  <= CMP_W'(nume_s5) >= CMP_W'({vv_s5, {LAM_W{1'b0}}});
			nume_s6 <= nume_s5;
			vv_s6   <= vv_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
			u_s6    <= u_s5;
			v_s6    <= v_s5;
		end
	end

	// divider: 32 quotient bits, geometry travels alongside
	logic                   div_valid;
	logic [LAM_W-1:0]       div_quo;
	logic [DSB_W-1:0]       div_sb;
	logic [2:0][DIFF_W-1:0] du, dv;
	logic                   dneg, dzero, dbig;

	plp_div #(
		.NUM_W (NUM_W),
		.DEN_W (SUM_W),
		.QUO_W (LAM_W),
		.SB_W  (DSB_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.num       (nume_s6),
		.den       (vv_s6),
		.sb        ({u_s6, v_s6, neg_s6, zero_s6, big_s6}),
		.out_valid (div_valid),
		.quo       (div_quo),
		.out_sb    (div_sb)
	);

	assign {du, dv, dneg, dzero, dbig} = div_sb;

	// stage 7: clamp lambda to its signed range
	logic                   vld_s7, zero_s7, neg_s7, sat_s7;
	logic [LAM_W-1:0]       lam_s7, lmag_s7;
	logic [2:0][DIFF_W-1:0] u_s7, v_s7;
	logic [LAM_W-1:0]       lim_c, mag_c;
	logic                   sat_c;

	always_comb begin
		lim_c = dneg ? LAM_NEG_MAG : LAM_POS_MAX;
		sat_c = dbig || (div_quo > lim_c);
		mag_c = sat_c ? lim_c : div_quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lmag_s7 <= mag_c;
			lam_s7  <= dneg ? (~mag_c + 1'b1) : mag_c;
			sat_s7  <= sat_c;
			neg_s7  <= dneg;
			zero_s7 <= dzero;
			u_s7    <= du;
			v_s7    <= dv;
		end
	end

	// stage 8: |lambda| * |v_k|
	logic                     vld_s8, zero_s8, sat_s8;
	logic [LAM_W-1:0]         lam_s8;
	logic [2:0][PROD_W-2:0]   wp_s8;
	logic [2:0]               wsgn_s8;
	logic [2:0][DIFF_W-1:0]   u_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				wp_s8[k]   <= (PROD_W-1)'(lmag_s7) * (PROD_W-1)'(mag_diff(v_s7[k]));
				wsgn_s8[k] <= neg_s7 ^ v_s7[k][DIFF_W-1];
			end
			lam_s8  <= lam_s7;
			sat_s8  <= sat_s7;
			zero_s8 <= zero_s7;
			u_s8    <= u_s7;
		end
	end

	// stage 9: round off the fraction, signed offset w
	logic                   vld_s9, zero_s9, sat_s9;
	logic [LAM_W-1:0]       lam_s9;
	logic [2:0][R_W-1:0]    r_s9;
	logic [2:0][W_W-1:0]    w_s9;
	logic [2:0][DIFF_W-1:0] u_s9;
	logic [2:0][PROD_W-1:0] rsum_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rsum_c[k] = PROD_W'(wp_s8[k]) + (PROD_W'(1) << (FRAC_BITS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				r_s9[k] <= rsum_c[k][PROD_W-1:FRAC_BITS];
				w_s9[k] <= wsgn_s8[k] ? (~W_W'(rsum_c[k][PROD_W-1:FRAC_BITS]) + 1'b1)
				                      : W_W'(rsum_c[k][PROD_W-1:FRAC_BITS]);
			end
			lam_s9  <= lam_s8;
			sat_s9  <= sat_s8;
			zero_s9 <= zero_s8;
			u_s9    <= u_s8;
		end
	end

	// stage 10: e = u - w
	logic                vld_s10, zero_s10, sat_s10;
	logic [LAM_W-1:0]    lam_s10;
	logic [2:0][R_W-1:0] r_s10;
	logic [2:0][E_W-1:0] e_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e_s10[k] <= {{(E_W-DIFF_W){u_s9[k][DIFF_W-1]}}, u_s9[k]}
				          - {w_s9[k][W_W-1], w_s9[k]};
			end
			r_s10    <= r_s9;
			lam_s10  <= lam_s9;
			sat_s10  <= sat_s9;
			zero_s10 <= zero_s9;
		end
	end

	// stage 11: magnitudes cut to 33 bits; anything wider already clamps the root
	logic                   vld_s11, zero_s11, sat_s11, ova_s11, ovp_s11;
	logic [LAM_W-1:0]       lam_s11;
	logic [2:0][DIST_W-1:0] wm_s11, em_s11;
	logic [2:0][E_W-1:0]    em_c;
	logic                   ova_c, ovp_c;

	always_comb begin
		ova_c = 1'b0;
		ovp_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			em_c[k] = e_s10[k][E_W-1] ? (~e_s10[k] + 1'b1) : e_s10[k];
			ova_c   = ova_c | (|r_s10[k][R_W-1:DIST_W]);
			ovp_c   = ovp_c | (|em_c[k][E_W-1:DIST_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				wm_s11[k] <= r_s10[k][DIST_W-1:0];
				em_s11[k] <= em_c[k][DIST_W-1:0];
			end
			ova_s11  <= ova_c;
			ovp_s11  <= ovp_c;
			lam_s11  <= lam_s10;
			sat_s11  <= sat_s10;
			zero_s11 <= zero_s10;
		end
	end

	// stage 12: squares
	logic                   vld_s12, zero_s12, sat_s12, ova_s12, ovp_s12;
	logic [LAM_W-1:0]       lam_s12;
	logic [2:0][PROD_W-1:0] wsq_s12, esq_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				wsq_s12[k] <= PROD_W'(wm_s11[k]) * PROD_W'(wm_s11[k]);
				esq_s12[k] <= PROD_W'(em_s11[k]) * PROD_W'(em_s11[k]);
			end
			ova_s12  <= ova_s11;
			ovp_s12  <= ovp_s11;
			lam_s12  <= lam_s11;
			sat_s12  <= sat_s11;
			zero_s12 <= zero_s11;
		end
	end

	// stage 13: sums of squares; a sum of 2^66 or more has a root past the limit
	logic                vld_s13, zero_s13, sat_s13, clpa_s13, clpp_s13;
	logic [LAM_W-1:0]    lam_s13;
	logic [PROD_W-1:0]   rada_s13, radp_s13;
	logic [SUM_W-1:0]    sa_c, sp_c;

	always_comb begin
		sa_c = '0;
		sp_c = '0;
		for (int k = 0; k < 3; k++) begin
			sa_c = sa_c + SUM_W'(wsq_s12[k]);
			sp_c = sp_c + SUM_W'(esq_s12[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clpa_s13 <= ova_s12 | (|sa_c[SUM_W-1:PROD_W]);
			clpp_s13 <= ovp_s12 | (|sp_c[SUM_W-1:PROD_W]);
			rada_s13 <= sa_c[PROD_W-1:0];
			radp_s13 <= sp_c[PROD_W-1:0];
			lam_s13  <= lam_s12;
			sat_s13  <= sat_s12;
			zero_s13 <= zero_s12;
		end
	end

	// two square root pipes in lock step; the along pipe carries the flags
	logic              sqa_valid, sqp_valid;
	logic [DIST_W-1:0] roota, rootp;
	logic [ASB_W-1:0]  sqa_sb;
	logic              sqp_clp;
	logic [LAM_W-1:0]  flam;
	logic              fzero, fsat, fclpa;

	plp_sqrt #(
		.RW   (DIST_W),
		.SB_W (ASB_W)
	) u_sqrt_along (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s13),
		.rad       (rada_s13),
		.sb        ({lam_s13, zero_s13, sat_s13, clpa_s13}),
		.out_valid (sqa_valid),
		.root      (roota),
		.out_sb    (sqa_sb)
	);

	plp_sqrt #(
		.RW   (DIST_W),
		.SB_W (1)
	) u_sqrt_perp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s13),
		.rad       (radp_s13),
		.sb        (clpp_s13),
		.out_valid (sqp_valid),
		.root      (rootp),
		.out_sb    (sqp_clp)
	);

	assign {flam, fzero, fsat, fclpa} = sqa_sb;

	// output register; coinciding line points give zeros and the flag
	logic [LAM_W-1:0]  lam_q;
	logic [DIST_W-1:0] along_q, perp_q;
	logic              deg_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sqa_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fzero) begin
				lam_q   <= '0;
				along_q <= '0;
				perp_q  <= '0;
				deg_q   <= 1'b1;
				sat_q   <= 1'b0;
			end else begin
				lam_q   <= flam;
				along_q <= fclpa ? DIST_MAX : roota;
				perp_q  <= sqp_clp ? DIST_MAX : rootp;
				deg_q   <= 1'b0;
				sat_q   <= fsat;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign line_param      = lam_q;
	assign dist_along      = along_q;
	assign dist_to_line    = perp_q;
	assign degenerate      = deg_q;
	assign param_saturated = sat_q;

`ifndef SYNTHESIS
	a_sqrt_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		sqa_valid == sqp_valid)
		else $error("square root pipes out of step");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> line_param == '0 && dist_along == '0
			&& dist_to_line == '0 && !param_saturated)
		else $error("degenerate result with non-zero fields");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && param_saturated |->
			(line_param == LAM_POS_MAX) || (line_param == LAM_NEG_MAG))
		else $error("saturated lambda not at a range limit");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s13) && $stable(lam_s13))
		else $error("pipeline moved during an output stall");
`endif

endmodule
